// ===== sv/afn_pkg.sv =====
package afn_pkg;

  localparam logic [7:0] LeadByte = 8'hC3;

  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqPtrW  = $clog2(OutqDepth);
  localparam int unsigned OutqCntW  = OutqPtrW + 1;

  localparam logic [7:0] LengthMax = 8'hFF;

  typedef struct packed {
    logic [6:0] letter;
    logic       letter_valid;
    logic       token_end;
    logic [7:0] word_length;
    logic       run_last;
  } result_t;

  // Results produced by one byte as it leaves the input register.
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  // A zero letter means the byte has no mapping and is dropped.
  function automatic logic [6:0] fold_single(input logic [7:0] c);
    logic [6:0] l;
    l = 7'd0;
    case (c) inside
      [8'hC0:8'hC5], [8'hE0:8'hE5]:                 l = 7'h61;
      8'hC7, 8'hE7:                                 l = 7'h63;
      [8'hC8:8'hCB], [8'hE8:8'hEB]:                 l = 7'h65;
      [8'hCC:8'hCF], [8'hEC:8'hEF]:                 l = 7'h69;
      8'hD1, 8'hF1:                                 l = 7'h6E;
      [8'hD2:8'hD6], 8'hD8, [8'hF2:8'hF6], 8'hF8:   l = 7'h6F;
      [8'hD9:8'hDC], [8'hF9:8'hFC]:                 l = 7'h75;
      8'hDD, 8'hFD, 8'hFF:                          l = 7'h79;
      default:                                      l = 7'd0;
    endcase
    return l;
  endfunction

  function automatic logic [6:0] fold_pair(input logic [7:0] c);
    logic [6:0] l;
    l = 7'd0;
    case (c) inside
      [8'h80:8'h85], [8'hA0:8'hA5]:                 l = 7'h61;
      8'h87, 8'hA7:                                 l = 7'h63;
      [8'h88:8'h8B], [8'hA8:8'hAB]:                 l = 7'h65;
      [8'h8C:8'h8F], [8'hAC:8'hAF]:                 l = 7'h69;
      8'h91, 8'hB1:                                 l = 7'h6E;
      [8'h92:8'h96], 8'h98, [8'hB2:8'hB6], 8'hB8:   l = 7'h6F;
      [8'h99:8'h9C], [8'hB9:8'hBC]:                 l = 7'h75;
      default:                                      l = 7'd0;
    endcase
    return l;
  endfunction

  function automatic logic [6:0] fold_ascii(input logic [7:0] c);
    logic [6:0] l;
    l = 7'd0;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      l = c[6:0] | 7'h20;
    end
    return l;
  endfunction

endpackage

// ===== sv/afn_fold.sv =====
module afn_fold (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_byte_i,
  input  logic           token_last_i,
  input  logic           room_i,
  output afn_pkg::push_t push_o
);
  import afn_pkg::*;

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       lead_q, lead_d;
  logic [7:0] count_q, count_d;

  logic       advance;
  logic [6:0] l0, l1, la, lb;
  logic       set_lead;
  logic       has_a, has_b;
  logic [7:0] cnt_a, cnt_b;

  assign advance    = vld_q && room_i;
  assign in_stall_o = vld_q && !room_i;

  always_comb begin
    l0       = 7'd0;
    l1       = 7'd0;
    set_lead = 1'b0;
    if (lead_q) begin
      if (byte_q[7]) begin
        l0 = fold_pair(byte_q);
      end else begin
        // The held lead byte was not a pair after all: fold it on its own first.
        l0 = fold_single(LeadByte);
        l1 = fold_ascii(byte_q);
      end
    end else if (!byte_q[7]) begin
      l0 = fold_ascii(byte_q);
    end else if (byte_q == LeadByte && !last_q) begin
      set_lead = 1'b1;
    end else begin
      l0 = fold_single(byte_q);
    end

    if (l0 == 7'd0) begin
      la = l1;
      lb = 7'd0;
    end else begin
      la = l0;
      lb = l1;
    end
    has_a = (la != 7'd0);
    has_b = (lb != 7'd0);
    cnt_a = (has_a && count_q != LengthMax) ? count_q + 8'd1 : count_q;
    cnt_b = (has_b && cnt_a != LengthMax) ? cnt_a + 8'd1 : cnt_a;

    push_o.r0.letter       = la;
    push_o.r0.letter_valid = has_a;
    push_o.r0.token_end    = last_q && !has_b;
    push_o.r0.word_length  = cnt_a;
    push_o.r0.run_last     = !has_b;
    push_o.r1.letter       = lb;
    push_o.r1.letter_valid = 1'b1;
    push_o.r1.token_end    = last_q;
    push_o.r1.word_length  = cnt_b;
    push_o.r1.run_last     = 1'b1;

    if (!advance) begin
      push_o.num = 2'd0;
    end else if (has_b) begin
      push_o.num = 2'd2;
    end else if (has_a || last_q) begin
      push_o.num = 2'd1;
    end else begin
      push_o.num = 2'd0;
    end

    count_d = count_q;
    lead_d  = lead_q;
    if (advance) begin
      count_d = last_q ? 8'd0 : cnt_b;
      lead_d  = last_q ? 1'b0 : set_lead;
    end

    vld_d = vld_q;
    if (in_valid_i && !in_stall_o) begin
      vld_d = 1'b1;
    end else if (advance) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      lead_q  <= 1'b0;
      count_q <= 8'd0;
    end else begin
      vld_q   <= vld_d;
      lead_q  <= lead_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= in_byte_i;
      last_q <= token_last_i;
    end
  end

endmodule

// ===== sv/afn_outq.sv =====
module afn_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  afn_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output afn_pkg::result_t head_o
);
  import afn_pkg::*;

  result_t             mem_q [OutqDepth];
  logic [OutqPtrW-1:0] rd_q, rd_d, wr_q, wr_d, wr_next;
  logic [OutqCntW-1:0] cnt_q, cnt_d;
  logic                pop;

  // Room for the worst case of two results, judged before this cycle's transfer.
  assign room_o      = (cnt_q <= OutqCntW'(OutqDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_q];
  assign wr_next     = wr_q + OutqPtrW'(1);

  always_comb begin
    rd_d  = pop ? rd_q + OutqPtrW'(1) : rd_q;
    wr_d  = wr_q + OutqPtrW'(push_i.num);
    cnt_d = cnt_q + OutqCntW'(push_i.num) - OutqCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

endmodule

// ===== sv/accent_folding_normalizer.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_byte_i, token_last_i
// out      output     out_valid_o / out_stall_i  out_letter_o, letter_valid_o, token_end_o,
//                                                word_length_o, run_last_o
//
// A byte is held in the input register until the queue has room; it is then folded and its
// results can be taken the cycle after. One byte is accepted every cycle while the output is
// drained; a byte yielding two letters adds a result that the four-entry output queue absorbs.
// The input register stalls when the queue cannot take two more results.
// Reset clears the held lead byte, the letter count and the queue.
module accent_folding_normalizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       token_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] out_letter_o,
  output logic       letter_valid_o,
  output logic       token_end_o,
  output logic [7:0] word_length_o,
  output logic       run_last_o
);
  import afn_pkg::*;

  push_t   push;
  result_t head;
  logic    room;

  afn_fold u_fold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .token_last_i (token_last_i),
    .room_i       (room),
    .push_o       (push)
  );

  afn_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign out_letter_o   = head.letter;
  assign letter_valid_o = head.letter_valid;
  assign token_end_o    = head.token_end;
  assign word_length_o  = head.word_length;
  assign run_last_o     = head.run_last;

endmodule

// ===== verif/tb_accent_folding_normalizer.sv =====
module tb_accent_folding_normalizer;

  import afn_pkg::*;

  localparam int unsigned RandomBytes = 500;
  localparam int unsigned LongToken   = 300;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  // Holds the folding state and the queue of results still owed by the block.
  class letter_scoreboard;
    bit         lead_held;
    logic [7:0] letter_total;
    result_t    owed[$];
    int         errors;

    function new();
      lead_held    = 1'b0;
      letter_total = 8'd0;
      errors       = 0;
    endfunction

    task report(string what);
      $display("[%0t] error: %s", $time, what);
      errors++;
    endtask

    // Letters share one layout by the low five bits, both for Latin-1 bytes
    // from 0xC0 up and for UTF-8 tails; only Latin-1 maps offset 0x1D to y.
    function logic [6:0] offset_letter(logic [4:0] k, bit with_y);
      if (k <= 5'h05) return 7'h61;
      if (k == 5'h07) return 7'h63;
      if (k >= 5'h08 && k <= 5'h0B) return 7'h65;
      if (k >= 5'h0C && k <= 5'h0F) return 7'h69;
      if (k == 5'h11) return 7'h6E;
      if ((k >= 5'h12 && k <= 5'h16) || k == 5'h18) return 7'h6F;
      if (k >= 5'h19 && k <= 5'h1C) return 7'h75;
      if (k == 5'h1D && with_y) return 7'h79;
      return 7'd0;
    endfunction

    function logic [6:0] latin1_letter(logic [7:0] c);
      if (c == 8'hFF) return 7'h79;
      if (c < 8'hC0) return 7'd0;
      return offset_letter(c[4:0], 1'b1);
    endfunction

    function logic [6:0] tail_letter(logic [7:0] c);
      if (c[6]) return 7'd0;
      return offset_letter(c[4:0], 1'b0);
    endfunction

    function logic [6:0] ascii_letter(logic [7:0] c);
      logic [6:0] low;
      low = c[6:0] | 7'h20;
      if (c[7] || low < 7'h61 || low > 7'h7A) return 7'd0;
      return low;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [6:0] cand[$];
      result_t    res[2];
      int         n;
      n = 0;
      if (lead_held) begin
        lead_held = 1'b0;
        if (b[7]) begin
          cand.push_back(tail_letter(b));
        end else begin
          cand.push_back(latin1_letter(LeadByte));
          cand.push_back(ascii_letter(b));
        end
      end else if (!b[7]) begin
        cand.push_back(ascii_letter(b));
      end else if (b == LeadByte && !last) begin
        lead_held = 1'b1;
      end else begin
        cand.push_back(latin1_letter(b));
      end

      foreach (cand[i]) begin
        if (cand[i] != 7'd0) begin
          if (letter_total != LengthMax) letter_total++;
          res[n] = '{letter: cand[i], letter_valid: 1'b1, token_end: 1'b0,
                     word_length: letter_total, run_last: 1'b0};
          n++;
        end
      end
      if (last) begin
        if (n == 0) begin
          res[0] = '{letter: 7'd0, letter_valid: 1'b0, token_end: 1'b0,
                     word_length: letter_total, run_last: 1'b0};
          n = 1;
        end
        res[n-1].token_end = 1'b1;
        letter_total = 8'd0;
        lead_held    = 1'b0;
      end
      if (n > 0) res[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) owed.push_back(res[i]);
    endfunction

    task check_result(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result letter=%h valid=%b end=%b len=%0d last=%b",
                         got.letter, got.letter_valid, got.token_end, got.word_length,
                         got.run_last));
        return;
      end
      want = owed.pop_front();
      if (got.letter != want.letter)
        report($sformatf("out_letter %h, expected %h", got.letter, want.letter));
      if (got.letter_valid != want.letter_valid)
        report($sformatf("letter_valid %b, expected %b", got.letter_valid, want.letter_valid));
      if (got.token_end != want.token_end)
        report($sformatf("token_end %b, expected %b", got.token_end, want.token_end));
      if (got.word_length != want.word_length)
        report($sformatf("word_length %0d, expected %0d", got.word_length, want.word_length));
      if (got.run_last != want.run_last)
        report($sformatf("run_last %b, expected %b", got.run_last, want.run_last));
    endtask

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i      = 8'd0;
  logic       token_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [6:0] out_letter_o;
  logic       letter_valid_o;
  logic       token_end_o;
  logic [7:0] word_length_o;
  logic       run_last_o;

  letter_scoreboard sb = new();

  int unsigned cycles     = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned mode_left  = 0;
  stall_mode_e stall_mode = StallNone;

  accent_folding_normalizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .token_last_i  (token_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_letter_o  (out_letter_o),
    .letter_valid_o(letter_valid_o),
    .token_end_o   (token_end_o),
    .word_length_o (word_length_o),
    .run_last_o    (run_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("accent_folding_normalizer: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_byte(in_byte_i, token_last_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{letter: out_letter_o, letter_valid: letter_valid_o,
                        token_end: token_end_o, word_length: word_length_o,
                        run_last: run_last_o});
    end
  end

  // The receiver moves between stretches of different stall behaviour.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      StallNone:     out_stall_i = 1'b0;
      StallLight:    out_stall_i = ($urandom_range(0, 7) == 0);
      StallHeavy:    out_stall_i = ($urandom_range(0, 3) != 0);
      StallPeriodic: out_stall_i = (cycles % 3 == 0);
      default:       out_stall_i = 1'b0;
    endcase
  end

  // Presents one byte at a falling edge and holds it until the transfer.
  // Bursts of random length are mostly separated by random gaps with valid low.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_byte_i    = b;
    token_last_i = last;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    bytes_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_random_token(input int unsigned len);
    int unsigned i;
    int unsigned pick;
    i = 0;
    while (i < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_byte(8'($urandom_range(0, 1) ? $urandom_range(8'h41, 8'h5A)
                                          : $urandom_range(8'h61, 8'h7A)), i == len - 1);
      end else if (pick < 55) begin
        send_byte(8'($urandom_range(0, 127)), i == len - 1);
      end else if (pick < 75) begin
        send_byte(LeadByte, i == len - 1);
        if (i < len - 1) begin
          i++;
          send_byte(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(8'h80, 8'hBF)),
                    i == len - 1);
        end
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(128, 255)), i == len - 1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
      i++;
    end
  endtask

  initial begin
    int unsigned start;
    bit          long_done;
    long_done = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Letter edges, non-letter ASCII and an unmapped high byte ending the token,
    // which leaves a lone token-end transfer with no letter.
    send_byte(8'h41, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h7A, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);
    // UTF-8 pairs, an unmapped tail, a lead followed by a lead, and a lead
    // followed by an ASCII letter, which gives two letters from one byte.
    send_byte(LeadByte, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(LeadByte, 1'b0);
    send_byte(8'hBC, 1'b0);
    send_byte(LeadByte, 1'b0);
    send_byte(8'hBD, 1'b0);
    send_byte(LeadByte, 1'b0);
    send_byte(LeadByte, 1'b0);
    send_byte(LeadByte, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hC6, 1'b0);
    send_byte(LeadByte, 1'b1);
    // A held lead closed by a non-letter final byte.
    send_byte(LeadByte, 1'b0);
    send_byte(8'h20, 1'b1);

    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      if (!long_done && bytes_sent - start > RandomBytes / 3) begin
        // Long enough for the letter count to saturate.
        long_done = 1'b1;
        for (int unsigned i = 0; i < LongToken; i++) begin
          send_byte(8'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(8'h61, 8'h7A)),
                    i == LongToken - 1);
        end
      end else begin
        send_random_token($urandom_range(1, 12));
      end
    end
    in_valid_i = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("accent_folding_normalizer: match");
    end else begin
      $display("accent_folding_normalizer: mismatch");
    end
    $finish;
  end

endmodule
